// ===== hdl/sorted_priority_queue_top_macros.svh =====
// Assertion macros for the sorted priority queue checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define SPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked on every rising edge outside reset.
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue_top.
package spq_pkg;

	localparam int SPQ_CAPACITY = 16;
	localparam int VAL_W        = 32;
	localparam int CNT_OUT_W    = 5;
	localparam int M_DATA_W     = 80;

	// request kinds carried in s_tuser
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	// command broadcast to every cell for one step
	typedef struct packed {
		logic             ins_en;
		logic             rem_en;
		logic [VAL_W-1:0] val;
	} spq_cmd_t;

	// what a cell shows its neighbors
	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             valid;
		logic             gt;     // valid and value > incoming value
	} spq_link_t;

endpackage

// ===== hdl/spq_cell.sv =====
// One slot of the sorted row: holds one value, compares it with the request.
// Depends on spq_pkg.
module spq_cell (
	input  logic              clk,
	input  spq_pkg::spq_cmd_t cmd,
	input  logic              own_valid,
	input  spq_pkg::spq_link_t left,
	input  spq_pkg::spq_link_t right,
	output spq_pkg::spq_link_t link,
	output logic [spq_pkg::VAL_W-1:0] nxt_value
);
	import spq_pkg::*;

	logic [VAL_W-1:0] value_q;
	logic             gt;

	assign gt = own_valid && ($signed(value_q) > $signed(cmd.val));

	assign link.value = value_q;
	assign link.valid = own_valid;
	assign link.gt    = gt;

	always_comb begin
		nxt_value = value_q;
		if (cmd.ins_en) begin
			// shift right past larger values, or take the new one at its slot
			if (left.gt) begin
				nxt_value = left.value;
			end else if (left.valid && (gt || !own_valid)) begin
				nxt_value = cmd.val;
			end
		end else if (cmd.rem_en) begin
			nxt_value = right.value;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= nxt_value;
	end

endmodule

// ===== hdl/sorted_priority_queue_top.sv =====
// Top level of the sorted min-priority queue: a row of compare cells.
// Depends on spq_pkg and spq_cell.
//
// Channel  Dir  Transfer when          Payload
// s_*      in   s_tvalid & s_tready    tuser: req_type; tdata: value
// m_*      out  m_tvalid & m_tready    tdata: head, removed, count, flags
//
// Cycles: one request per clock while s_tready is high. Every cell compares its value with the
// request in parallel and takes its own, its neighbor's or the new value,
// so the row shifts one place per transfer; the result is registered.
// Reset: arst_n clears the count and the output valid flag; cell contents
// are don't-care until written, since only the first count cells are read.
// Stalls: s_tready drops only while a result waits and m_tready is low.
module sorted_priority_queue_top #(
	parameter int CAPACITY = spq_pkg::SPQ_CAPACITY
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [spq_pkg::VAL_W-1:0]     s_tdata,  // [31:0] value
	input  logic                          s_tuser,  // [0] req_type
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [31:0] head_value, [32] head_valid, [64:33] removed_value,
	// [65] removed_valid, [70:66] entry_count, [71] overflow,
	// [72] underflow, [79:73] zero
	output logic [spq_pkg::M_DATA_W-1:0]  m_tdata
);
	import spq_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_nxt;
	logic          accept;
	logic          full;
	logic          empty;
	spq_cmd_t      cmd;

	spq_link_t        links [CAPACITY];
	logic [VAL_W-1:0] nxt_vals [CAPACITY];

	// output register
	logic             out_valid_q;
	logic [VAL_W-1:0] head_value_q;
	logic             head_valid_q;
	logic [VAL_W-1:0] removed_value_q;
	logic             removed_valid_q;
	logic [CNT_OUT_W-1:0] entry_count_q;
	logic             overflow_q;
	logic             underflow_q;

	logic [CW+CNT_OUT_W-1:0] count_ext;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign full     = (count_q == CW'(CAPACITY));
	assign empty    = (count_q == '0);

	assign cmd.ins_en = accept && (s_tuser == REQ_INSERT) && !full;
	assign cmd.rem_en = accept && (s_tuser == REQ_REMOVE) && !empty;
	assign cmd.val    = s_tdata;

	always_comb begin
		count_nxt = count_q;
		if (cmd.ins_en) begin
			count_nxt = count_q + CW'(1);
		end else if (cmd.rem_en) begin
			count_nxt = count_q - CW'(1);
		end
	end

	// row of cells; a cell is occupied when its index is below the count
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		spq_link_t left_link;
		spq_link_t right_link;
		logic      own_valid;

		assign own_valid = (count_q > CW'(i));

		if (i == 0) begin : g_first
			// head cell: nothing to its left, always allowed to take the value
			assign left_link.value = '0;
			assign left_link.valid = 1'b1;
			assign left_link.gt    = 1'b0;
		end else begin : g_mid
			assign left_link = links[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_link.value = '0;
			assign right_link.valid = 1'b0;
			assign right_link.gt    = 1'b0;
		end else begin : g_inner
			assign right_link = links[i+1];
		end

		spq_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.own_valid (own_valid),
			.left      (left_link),
			.right     (right_link),
			.link      (links[i]),
			.nxt_value (nxt_vals[i])
		);
	end

	assign count_ext = {{CNT_OUT_W{1'b0}}, count_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, loaded on each input transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			head_valid_q    <= (count_nxt != '0);
			head_value_q    <= (count_nxt != '0) ? nxt_vals[0] : '0;
			removed_valid_q <= cmd.rem_en;
			removed_value_q <= cmd.rem_en ? links[0].value : '0;
			entry_count_q   <= count_ext[CNT_OUT_W-1:0];
			overflow_q      <= (s_tuser == REQ_INSERT) && full;
			underflow_q     <= (s_tuser == REQ_REMOVE) && empty;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, underflow_q, overflow_q, entry_count_q, removed_valid_q,
		removed_value_q, head_valid_q, head_value_q};

endmodule

// ===== hdl/spq_checker.sv =====
// Port-level checker for sorted_priority_queue_top, with its bind.
// Depends on spq_pkg and sorted_priority_queue_top_macros.svh.
`include "sorted_priority_queue_top_macros.svh"

module spq_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic [spq_pkg::VAL_W-1:0]    s_tdata,
	input logic                         s_tuser,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [spq_pkg::M_DATA_W-1:0] m_tdata
);
	import spq_pkg::*;

	// a stalled result holds
	`SPQ_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// with no result pending the input side is open
	`SPQ_ASSERT_IMP(a_open, clk, arst_n, !m_tvalid, s_tready, "input stalled with empty output")

	// each input transfer yields a result in the next cycle
	`SPQ_ASSERT_NEXT(a_result, clk, arst_n, s_tvalid && s_tready, m_tvalid, "no result after transfer")

	// a successful remove raises neither error flag
	`SPQ_ASSERT_IMP(a_flags, clk, arst_n, m_tvalid && m_tdata[65], !m_tdata[71] && !m_tdata[72], "removed with error flag")

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (.*);
